// ===== rtl/mfht_pkg.sv =====
`timescale 1ns / 1ps

package mfht_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int POS_W = $clog2(DEPTH);

    localparam int FREQ_W  = 17;
    localparam int RSSI_W  = 8;
    localparam int EDGE_W  = 32;
    localparam int IDX_W   = 4;
    localparam int TOTAL_W = 5;

    typedef enum logic [2:0] {
        OUT_IGNORED  = 3'd0,
        OUT_APPENDED = 3'd1,
        OUT_EVICTED  = 3'd2,
        OUT_PROMOTED = 3'd3,
        OUT_READ_OK  = 3'd4,
        OUT_READ_EMP = 3'd5
    } outcome_t;

    typedef struct packed {
        logic [FREQ_W-1:0]        freq;
        logic signed [RSSI_W-1:0] rssi;
        logic [EDGE_W-1:0]        edges;
    } entry_t;

    // Per-cell control: shift_en is the broadcast record strobe, the rest
    // describe this cell's place in the list.
    typedef struct packed {
        logic shift_en;
        logic cell_valid;
        logic prev_valid;
        logic match_in;
    } cell_ctl_t;

endpackage

// ===== rtl/mru_frequency_hit_table.sv =====
// Most-recently-used table of frequency hits, built as a row of cells.
// Request channel: req_valid/req_stall with mode, freq_units, rssi_dbm,
// edge_count and read_index. Mode 0 records a hit unless freq_units is 0,
// mode 1 reads the entry at read_index. Response channel: rsp_valid/rsp_stall
// with outcome, promoted_from, entry_total and the out_* data fields.
// Every request gives exactly one response, registered in the cycle after the
// request is accepted. All cells compare the hit frequency in the same cycle,
// and on a record the cells down to a match, or to the list's end, shift
// their entry one place down; a request is taken every cycle unless stalled.
// While a response waits under rsp_stall, req_stall is raised and the list
// holds still; the pending response and its payload do not change.
// Reset clears the entry count and the response valid; the list is then
// empty and the entry contents are never read before being written.
`timescale 1ns / 1ps

module mru_frequency_hit_table (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  logic                              mode,
    input  logic [mfht_pkg::FREQ_W-1:0]       freq_units,
    input  logic signed [mfht_pkg::RSSI_W-1:0] rssi_dbm,
    input  logic [mfht_pkg::EDGE_W-1:0]       edge_count,
    input  logic [mfht_pkg::IDX_W-1:0]        read_index,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output logic [2:0]                        outcome,
    output logic [3:0]                        promoted_from,
    output logic [mfht_pkg::TOTAL_W-1:0]      entry_total,
    output logic [mfht_pkg::FREQ_W-1:0]       out_freq_units,
    output logic signed [mfht_pkg::RSSI_W-1:0] out_rssi_dbm,
    output logic [mfht_pkg::EDGE_W-1:0]       out_edge_count
);
    import mfht_pkg::*;

    entry_t    req_entry;
    entry_t    cell_entry [DEPTH];
    entry_t    chain_in   [DEPTH];
    logic      cell_hit   [DEPTH];
    logic      chain_match [DEPTH+1];
    cell_ctl_t cell_ctl   [DEPTH];

    logic             req_fire;
    logic             record_en;
    logic             found;
    logic [POS_W-1:0] hit_pos;
    logic             rd_ok;
    entry_t           rd_entry;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;

    outcome_t             outcome_reg,   outcome_next;
    logic [3:0]           from_reg,      from_next;
    logic [TOTAL_W-1:0]   total_reg,     total_next;
    logic [FREQ_W-1:0]    ofreq_reg,     ofreq_next;
    logic signed [RSSI_W-1:0] orssi_reg, orssi_next;
    logic [EDGE_W-1:0]    oedge_reg,     oedge_next;

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign req_fire  = req_valid && !req_stall;
    assign record_en = req_fire && !mode && (freq_units != '0);

    assign req_entry.freq  = freq_units;
    assign req_entry.rssi  = rssi_dbm;
    assign req_entry.edges = edge_count;

    assign chain_match[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            if (g == 0)
            begin : g_head
                assign chain_in[g]            = req_entry;
                assign cell_ctl[g].prev_valid = 1'b1;
            end
            else
            begin : g_body
                assign chain_in[g]            = cell_entry[g-1];
                assign cell_ctl[g].prev_valid = cell_ctl[g-1].cell_valid;
            end
            assign cell_ctl[g].shift_en   = record_en;
            assign cell_ctl[g].cell_valid = count_reg > CNT_W'(g);
            assign cell_ctl[g].match_in   = chain_match[g];

            mfht_cell u_cell (
                .clk        (clk),
                .ctl        (cell_ctl[g]),
                .prev_entry (chain_in[g]),
                .key_freq   (freq_units),
                .entry      (cell_entry[g]),
                .hit        (cell_hit[g]),
                .match_out  (chain_match[g+1])
            );
        end
    endgenerate

    assign found = chain_match[DEPTH];

    // At most one cell matches, so an OR of the positions encodes it.
    always_comb
    begin
        hit_pos = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (cell_hit[i])
            begin
                hit_pos = hit_pos | POS_W'(i);
            end
        end
    end

    always_comb
    begin
        rd_ok    = 1'b0;
        rd_entry = cell_entry[0];
        for (int i = 0; i < DEPTH; i++)
        begin
            if (32'(read_index) == 32'(i))
            begin
                rd_ok    = cell_ctl[i].cell_valid;
                rd_entry = cell_entry[i];
            end
        end
    end

    always_comb
    begin
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg;
        outcome_next   = outcome_reg;
        from_next      = from_reg;
        total_next     = total_reg;
        ofreq_next     = ofreq_reg;
        orssi_next     = orssi_reg;
        oedge_next     = oedge_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        if (req_fire)
        begin
            rsp_valid_next = 1'b1;
            outcome_next   = OUT_IGNORED;
            from_next      = '0;
            ofreq_next     = '0;
            orssi_next     = '0;
            oedge_next     = '0;
            if (mode)
            begin
                if (rd_ok)
                begin
                    outcome_next = OUT_READ_OK;
                    ofreq_next   = rd_entry.freq;
                    orssi_next   = rd_entry.rssi;
                    oedge_next   = rd_entry.edges;
                end
                else
                begin
                    outcome_next = OUT_READ_EMP;
                end
            end
            else if (record_en)
            begin
                if (found)
                begin
                    outcome_next = OUT_PROMOTED;
                    from_next    = 4'(hit_pos);
                end
                else if (count_reg < CNT_W'(DEPTH))
                begin
                    outcome_next = OUT_APPENDED;
                    count_next   = count_reg + 1'b1;
                end
                else
                begin
                    outcome_next = OUT_EVICTED;
                    ofreq_next   = cell_entry[DEPTH-1].freq;
                end
            end
            total_next = TOTAL_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        outcome_reg <= outcome_next;
        from_reg    <= from_next;
        total_reg   <= total_next;
        ofreq_reg   <= ofreq_next;
        orssi_reg   <= orssi_next;
        oedge_reg   <= oedge_next;
    end

    assign rsp_valid      = rsp_valid_reg;
    assign outcome        = outcome_reg;
    assign promoted_from  = from_reg;
    assign entry_total    = total_reg;
    assign out_freq_units = ofreq_reg;
    assign out_rssi_dbm   = orssi_reg;
    assign out_edge_count = oedge_reg;

endmodule

// ===== rtl/mfht_cell.sv =====
`timescale 1ns / 1ps

module mfht_cell (
    input  logic               clk,
    input  mfht_pkg::cell_ctl_t ctl,
    input  mfht_pkg::entry_t   prev_entry,
    input  logic [mfht_pkg::FREQ_W-1:0] key_freq,
    output mfht_pkg::entry_t   entry,
    output logic               hit,
    output logic               match_out
);
    import mfht_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    logic   take_prev;

    assign hit       = ctl.cell_valid && (entry_reg.freq == key_freq);
    assign match_out = ctl.match_in || hit;

    // A cell takes its neighbour's entry when the list moves down through
    // it, that is when no match lies in front of it and the neighbour holds
    // a live entry.
    assign take_prev = ctl.shift_en && ctl.prev_valid && !ctl.match_in;

    always_comb
    begin
        entry_next = entry_reg;
        if (take_prev)
        begin
            entry_next = prev_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule
